/* hdl/swcfl_pkg.sv */
// ----------------------------------------------------------------------------
// swcfl_pkg: shared types and constants for the cfl time step block
// holds the register indexes, the controller command set and the datapath status
// ----------------------------------------------------------------------------
package swcfl_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_GRAVITY = 2'd0;
  localparam logic [1:0] REG_INV_DX  = 2'd1;
  localparam logic [1:0] REG_INV_DY  = 2'd2;

  localparam logic [31:0] GRAVITY_RESET = 32'd642689;
  localparam logic [31:0] INV_DX_RESET  = 32'd65536;
  localparam logic [31:0] INV_DY_RESET  = 32'd65536;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture the cell and form g*h and the momentum magnitudes
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_U_INIT,
    OP_DIV_STEP,
    OP_DIV_V_INIT,
    OP_SPEED,     // add celerity and update the running maxima
    OP_MUL,       // form the two denominator products
    OP_DEN,       // add them
    OP_DIV_T_INIT,
    OP_RESULT     // register the result and clear the maxima
  } op_t;

  typedef struct packed {
    op_t  op;
    logic save_u;  // take the quotient as u
    logic save_v;  // take the quotient as v
  } cmd_t;

  typedef struct packed {
    logic zero_height;
    logic last;
    logic iter_done;
  } stat_t;

endpackage

/* hdl/swcfl_ctrl.sv */
// ----------------------------------------------------------------------------
// swcfl_ctrl: controller for the cfl time step block
// sequences the square root and the divisions per cell, and the time step after the last cell
// ----------------------------------------------------------------------------
module swcfl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_busy,
  input  swcfl_pkg::stat_t  stat,
  output swcfl_pkg::cmd_t   cmd
);
  import swcfl_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_SQRT   = 4'd2;
  localparam logic [3:0] S_DIVU   = 4'd3;
  localparam logic [3:0] S_DIVV0  = 4'd4;
  localparam logic [3:0] S_DIVV   = 4'd5;
  localparam logic [3:0] S_SPEED  = 4'd6;
  localparam logic [3:0] S_LAST   = 4'd7;
  localparam logic [3:0] S_MUL    = 4'd8;
  localparam logic [3:0] S_DEN    = 4'd9;
  localparam logic [3:0] S_DIVT0  = 4'd10;
  localparam logic [3:0] S_DIVT   = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;
  localparam logic [3:0] S_SQRT0  = 4'd13;

  logic [3:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  // next state and command
  always_comb begin
    state_next  = state;
    cmd.op      = OP_NONE;
    cmd.save_u  = 1'b0;
    cmd.save_v  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.zero_height) state_next = S_LAST;
        else state_next = S_SQRT0;
      end
      S_SQRT0: begin
        cmd.op     = OP_SQRT_INIT;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (stat.iter_done) state_next = S_DIVU;
      end
      S_DIVU: begin
        cmd.op     = OP_DIV_U_INIT;
        state_next = S_DIVV0;
      end
      S_DIVV0: begin
        cmd.op = OP_DIV_STEP;
        if (stat.iter_done) begin
          cmd.save_u = 1'b1;
          state_next = S_DIVV;
        end
      end
      S_DIVV: begin
        cmd.op     = OP_DIV_V_INIT;
        state_next = S_SPEED;
      end
      S_SPEED: begin
        cmd.op = OP_DIV_STEP;
        if (stat.iter_done) begin
          cmd.save_v = 1'b1;
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        // speed is formed after v lands
        if (stat.zero_height) begin
          state_next = stat.last ? S_MUL : S_IDLE;
        end else begin
          cmd.op     = OP_SPEED;
          state_next = stat.last ? S_MUL : S_IDLE;
        end
      end
      S_MUL: begin
        if (!out_busy) begin
          cmd.op     = OP_MUL;
          state_next = S_DEN;
        end
      end
      S_DEN: begin
        cmd.op     = OP_DEN;
        state_next = S_DIVT0;
      end
      S_DIVT0: begin
        cmd.op     = OP_DIV_T_INIT;
        state_next = S_DIVT;
      end
      S_DIVT: begin
        cmd.op = OP_DIV_STEP;
        if (stat.iter_done) state_next = S_OUT;
      end
      S_OUT: begin
        cmd.op     = OP_RESULT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

/* hdl/swcfl_dp.sv */
// ----------------------------------------------------------------------------
// swcfl_dp: datapath for the cfl time step block
// shared restoring divider, bit-pair square root, maxima and result register
// ----------------------------------------------------------------------------
module swcfl_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  swcfl_pkg::cmd_t   cmd,
  output swcfl_pkg::stat_t  stat,
  input  logic [31:0]       gravity,
  input  logic [31:0]       inv_cell_width_x,
  input  logic [31:0]       inv_cell_width_y,
  input  logic [31:0]       height,
  input  logic [31:0]       momentum_x,
  input  logic [31:0]       momentum_y,
  input  logic              last_cell,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       time_step,
  output logic [31:0]       max_speed_x,
  output logic [31:0]       max_speed_y,
  output logic [1:0]        status
);
  import swcfl_pkg::*;

  localparam int QW = 32 + FRAC_BITS;          // dividend width of a velocity
  localparam int TW = 2 * FRAC_BITS + 1;       // dividend width of the time step
  localparam int NW = (QW > TW) ? QW : TW;     // shared dividend width
  localparam int CW = $clog2(NW + 1);

  // cell capture
  logic [31:0] h_r, mag_x, mag_y;
  logic        last_r, zero_r;
  logic [63:0] gh;

  // iteration state
  logic [63:0] sq_x, sq_res, sq_bit;
  logic [NW-1:0] dv_num, dv_quo;
  logic [64:0]   dv_rem;
  logic [63:0]   dv_den;
  logic [CW-1:0] cnt;
  logic          div_mode;

  logic [31:0] cel, u_r, v_r;
  logic [31:0] run_x, run_y;
  logic        zseen;
  logic [63:0] px, py, den;

  assign stat.zero_height = zero_r;
  assign stat.last        = last_r;
  assign stat.iter_done   = div_mode ? (cnt == '0) : (sq_bit == '0);

  // one restoring division step
  logic [64:0] rem_sh;
  assign rem_sh = {dv_rem[63:0], dv_num[NW-1]};

  // one square root step
  logic        sq_ge;
  assign sq_ge = sq_x >= (sq_res + sq_bit);

  // saturated speeds
  logic [32:0] sx, sy;
  assign sx = {1'b0, u_r} + {1'b0, cel};
  assign sy = {1'b0, v_r} + {1'b0, cel};
  logic [31:0] sxs, sys;
  assign sxs = sx[32] ? 32'hFFFF_FFFF : sx[31:0];
  assign sys = sy[32] ? 32'hFFFF_FFFF : sy[31:0];

  // saturated quotient
  logic [31:0] quo_sat;
  assign quo_sat = (|dv_quo[NW-1:32]) ? 32'hFFFF_FFFF : dv_quo[31:0];

  // leading bit pair for the root
  logic [63:0] top_bit;
  always_comb begin
    top_bit = '0;
    for (int i = 0; i < 32; i++) begin
      if (gh[2*i+1] | gh[2*i]) top_bit = 64'd1 << (2*i);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        h_r    <= height;
        mag_x  <= momentum_x[31] ? (32'd0 - momentum_x) : momentum_x;
        mag_y  <= momentum_y[31] ? (32'd0 - momentum_y) : momentum_y;
        last_r <= last_cell;
        zero_r <= (height == '0);
        gh     <= {32'd0, gravity} * {32'd0, height};
      end
      OP_SQRT_INIT: begin
        sq_x     <= gh;
        sq_res   <= '0;
        sq_bit   <= top_bit;
        div_mode <= 1'b0;
      end
      OP_SQRT_STEP: begin
        // root is complete once the bit has run out
        if (sq_bit == '0) begin
          cel <= sq_res[31:0];
        end else begin
          if (sq_ge) begin
            sq_x   <= sq_x - (sq_res + sq_bit);
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
      end
      OP_DIV_U_INIT, OP_DIV_V_INIT: begin
        dv_num   <= NW'({(op_t'(cmd.op) == OP_DIV_U_INIT) ? mag_x : mag_y,
                         {FRAC_BITS{1'b0}}});
        dv_den   <= {32'd0, h_r};
        dv_rem   <= '0;
        dv_quo   <= '0;
        cnt      <= CW'(NW);
        div_mode <= 1'b1;
      end
      OP_DIV_T_INIT: begin
        dv_num   <= NW'({1'b1, {(2*FRAC_BITS){1'b0}}});
        dv_den   <= den;
        dv_rem   <= '0;
        dv_quo   <= '0;
        cnt      <= CW'(NW);
        div_mode <= 1'b1;
      end
      OP_DIV_STEP: begin
        // quotient holds once all bits are in
        if (cnt != '0) begin
          dv_num <= dv_num << 1;
          if (rem_sh >= {1'b0, dv_den}) begin
            dv_rem <= rem_sh - {1'b0, dv_den};
            dv_quo <= {dv_quo[NW-2:0], 1'b1};
          end else begin
            dv_rem <= rem_sh;
            dv_quo <= {dv_quo[NW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
        end
      end
      OP_MUL: begin
        px <= ({32'd0, run_x} * {32'd0, inv_cell_width_x}) >> FRAC_BITS;
        py <= ({32'd0, run_y} * {32'd0, inv_cell_width_y}) >> FRAC_BITS;
      end
      OP_DEN: den <= px + py;
      default: ;
    endcase
    if (cmd.save_u) u_r <= quo_sat;
    if (cmd.save_v) v_r <= quo_sat;
  end

  // running maxima, zero-height flag and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      run_x     <= '0;
      run_y     <= '0;
      zseen     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.op == OP_LOAD && height == '0) zseen <= 1'b1;
      if (cmd.op == OP_SPEED) begin
        if (sxs > run_x) run_x <= sxs;
        if (sys > run_y) run_y <= sys;
      end
      if (cmd.op == OP_RESULT) begin
        out_valid   <= 1'b1;
        max_speed_x <= run_x;
        max_speed_y <= run_y;
        if (den == '0 || (|dv_quo[NW-1:32])) begin
          time_step <= 32'hFFFF_FFFF;
          status    <= {1'b1, zseen};
        end else begin
          time_step <= dv_quo[31:0];
          status    <= {1'b0, zseen};
        end
        run_x <= '0;
        run_y <= '0;
        zseen <= 1'b0;
      end
    end
  end

endmodule

/* hdl/shallow_water_cfl_timestep_top.sv */
// sequence: a cell of nonzero height is loaded, then runs the bit-pair square root and
//   the u and v divisions on the shared restoring divider before its speed updates the maxima
// a last cell adds the products, their sum and a time step division before the result beat
// throughput: one cell at a time; the next cell is taken when the last is done
// reset: running maxima, the zero-height flag and out_valid clear, configuration registers return to their defaults
module shallow_water_cfl_timestep_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] height,
  input  logic [31:0] momentum_x,
  input  logic [31:0] momentum_y,
  input  logic        last_cell,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] time_step,
  output logic [31:0] max_speed_x,
  output logic [31:0] max_speed_y,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import swcfl_pkg::*;

  logic [31:0] gravity, inv_dx, inv_dy;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= GRAVITY_RESET;
      inv_dx  <= INV_DX_RESET;
      inv_dy  <= INV_DY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRAVITY: gravity <= cfg_data;
        REG_INV_DX:  inv_dx  <= cfg_data;
        REG_INV_DY:  inv_dy  <= cfg_data;
        default: ;
      endcase
    end
  end

  swcfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_busy (out_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  swcfl_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .gravity          (gravity),
    .inv_cell_width_x (inv_dx),
    .inv_cell_width_y (inv_dy),
    .height           (height),
    .momentum_x       (momentum_x),
    .momentum_y       (momentum_y),
    .last_cell        (last_cell),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .time_step        (time_step),
    .max_speed_x      (max_speed_x),
    .max_speed_y      (max_speed_y),
    .status           (status)
  );

endmodule
